>>> rtl/srec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_pkg
// Types, codes and character helpers shared by the S-record line parser.
// ----------------------------------------------------------------------------
package srec_pkg;

   localparam logic [7:0]  CHAR_S       = 8'h53;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_F = 8'h46;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_F = 8'h66;

   localparam logic [7:0]  CHECKSUM_GOOD = 8'hFF;
   localparam logic [31:0] ADDR24_MASK   = 32'h00FF_FFFF;

   localparam logic [3:0]  TYPE_S1 = 4'd1;
   localparam logic [3:0]  TYPE_S2 = 4'd2;
   localparam logic [3:0]  TYPE_S3 = 4'd3;

   localparam logic [1:0]  STATUS_OK  = 2'd0;
   localparam logic [1:0]  STATUS_NA  = 2'd1;
   localparam logic [1:0]  STATUS_BAD = 2'd2;

   localparam logic [9:0]  CHAR_POS_MAX = 10'd1023;
   localparam logic [8:0]  BYTE_POS_MAX = 9'd511;

   typedef struct packed {
      logic        record_end;
      logic [31:0] byte_address;
      logic [7:0]  data_byte;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] nibble;
   } hex_type;

   // A character that is not a hex digit decodes to nibble zero.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.is_hex = 1'b1;
      h.nibble = 4'd0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         h.nibble = 4'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         h.nibble = 4'(c - CHAR_UPPER_A + 8'd10);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         h.nibble = 4'(c - CHAR_LOWER_A + 8'd10);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

>>> rtl/srec_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srec_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module srec_out_reg
   import srec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    slot_free,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The slot is free when empty or when its beat leaves in this cycle.
   assign slot_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (slot_free && load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/srecord_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_line_parser
// Decodes one S-record line per run of characters, emitting S1/S2/S3 data
// bytes with their addresses as they are decoded and a verdict at line end.
// ----------------------------------------------------------------------------
//   Channel | Ports  | Beat contents
//   input   | req_*  | tdata[7:0] character, tlast = line end (character ignored)
//   result  | rsp_*  | tdata address/byte/status, tlast = verdict beat
//
// Each beat is decoded in the cycle it is accepted and its result, if any,
// lands in the result register; one beat per clock is sustained unless the result side stalls.
// req_tready drops only while a result waits and rsp_tready is low.
// Reset is synchronous and clears the line state and empties the result register.
// A line-end beat always produces a verdict and returns the line state to reset.
module srecord_line_parser
   import srec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] byte_address, [39:32] data_byte,
                                    // [41:40] status, [47:42] zero
   output logic        rsp_tlast    // record_end
);

   logic [9:0]  char_pos_ff,  char_pos_in;
   logic [3:0]  high_nib_ff,  high_nib_in;
   logic [3:0]  rec_type_ff,  rec_type_in;
   logic [7:0]  count_ff,     count_in;
   logic [7:0]  sum_ff,       sum_in;
   logic [31:0] base_ff,      base_in;
   logic [8:0]  byte_pos_ff,  byte_pos_in;
   logic        bad_ff,       bad_in;

   logic        accept;
   logic        slot_free;
   logic        emit;
   rsp_type     result;
   rsp_type     rsp_out;
   hex_type     hex;
   logic [7:0]  byte_val;
   logic        addr_type;
   logic [8:0]  addr_len;
   logic        bad_now;
   logic [7:0]  count_now;

   assign req_tready = slot_free;
   assign accept     = req_tvalid && req_tready;
   assign hex        = hex_decode(req_tdata);
   assign byte_val   = {high_nib_ff, hex.nibble};
   assign addr_type  = (rec_type_ff == TYPE_S1) || (rec_type_ff == TYPE_S2)
                       || (rec_type_ff == TYPE_S3);
   assign addr_len   = 9'(rec_type_ff) + 9'd1;

   always_comb begin
      char_pos_in = char_pos_ff;
      high_nib_in = high_nib_ff;
      rec_type_in = rec_type_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      base_in     = base_ff;
      byte_pos_in = byte_pos_ff;
      bad_in      = bad_ff;
      emit        = 1'b0;
      bad_now     = bad_ff;
      count_now   = count_ff;
      result      = '0;

      if (req_tlast) begin
         emit              = 1'b1;
         result.record_end = 1'b1;
         result.status     = STATUS_OK;
         if (bad_ff || char_pos_ff < 10'd4 || char_pos_ff[0]
             || byte_pos_ff != 9'(count_ff) + 9'd1 || sum_ff != CHECKSUM_GOOD) begin
            result.status = STATUS_BAD;
         end else if (addr_type) begin
            if (byte_pos_ff < 9'(rec_type_ff) + 9'd3) begin
               result.status = STATUS_BAD;
            end
         end else begin
            result.status = STATUS_NA;
         end
         char_pos_in = '0;
         high_nib_in = '0;
         rec_type_in = '0;
         count_in    = '0;
         sum_in      = '0;
         base_in     = '0;
         byte_pos_in = '0;
         bad_in      = 1'b0;
      end else if (char_pos_ff == CHAR_POS_MAX) begin
         bad_in = 1'b1;
      end else begin
         char_pos_in = char_pos_ff + 10'd1;
         if (char_pos_ff == 10'd0) begin
            if (req_tdata != CHAR_S) begin
               bad_in = 1'b1;
            end
         end else if (char_pos_ff == 10'd1) begin
            if (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE) begin
               rec_type_in = 4'(req_tdata - CHAR_ZERO);
            end else begin
               rec_type_in = '0;
               bad_in      = 1'b1;
            end
         end else begin
            bad_now = bad_ff || !hex.is_hex;
            bad_in  = bad_now;
            // Even positions from the first hex digit carry the high nibble.
            if (!char_pos_ff[0]) begin
               high_nib_in = hex.nibble;
            end else begin
               if (byte_pos_ff == 9'd0) begin
                  count_now = byte_val;
               end
               count_in = count_now;
               sum_in   = sum_ff + byte_val;
               if (addr_type && byte_pos_ff >= 9'd1 && byte_pos_ff <= addr_len) begin
                  base_in = {base_ff[23:0], byte_val};
                  if (rec_type_ff == TYPE_S2) begin
                     base_in = base_in & ADDR24_MASK;
                  end
               end else if (addr_type && byte_pos_ff > addr_len
                            && byte_pos_ff < 9'(count_now) && !bad_now) begin
                  emit                = 1'b1;
                  result.byte_address = base_ff
                                        + 32'(byte_pos_ff - addr_len - 9'd1);
                  result.data_byte    = byte_val;
                  result.status       = STATUS_OK;
               end
               if (byte_pos_ff != BYTE_POS_MAX) begin
                  byte_pos_in = byte_pos_ff + 9'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_pos_ff <= '0;
         high_nib_ff <= '0;
         rec_type_ff <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         base_ff     <= '0;
         byte_pos_ff <= '0;
         bad_ff      <= 1'b0;
      end else if (accept) begin
         char_pos_ff <= char_pos_in;
         high_nib_ff <= high_nib_in;
         rec_type_ff <= rec_type_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         base_ff     <= base_in;
         byte_pos_ff <= byte_pos_in;
         bad_ff      <= bad_in;
      end
   end

   srec_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && emit),
      .load_data (result),
      .slot_free (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_out)
   );

   assign rsp_tdata = {6'd0, rsp_out.status, rsp_out.data_byte, rsp_out.byte_address};
   assign rsp_tlast = rsp_out.record_end;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the S-record line parser. Lines are built from
// address, data and type, optionally corrupted, and streamed one character
// per beat with a line-end beat after each. A line decoder inside the bench
// predicts every data byte and verdict; the result stream is compared in
// order while both sides idle in random bursts in most tests.
// ----------------------------------------------------------------------------
module tb_top
   import srec_pkg::*;
();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;     // [7:0] char_code
   logic        req_tlast = 1'b0;      // line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;             // [31:0] byte_address, [39:32] data_byte,
                                       // [41:40] status, [47:42] zero
   logic        rsp_tlast;             // record_end

   srecord_line_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Line decoder state kept by the bench.
   logic [9:0]  pred_char_pos;
   logic [3:0]  pred_high;
   logic [3:0]  pred_type;
   logic [7:0]  pred_count;
   logic [7:0]  pred_sum;
   logic [31:0] pred_base;
   logic [8:0]  pred_byte_pos;
   bit          pred_bad;

   rsp_type     expected_results[$];
   rsp_type     got;
   rsp_type     want;
   logic [7:0]  line_buf[$];
   int          error_count = 0;
   int          beats_sent = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   bit          tx_idle_enable = 1'b0;
   bit          rx_stall_enable = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("srecord_line_parser regression: fail");
      $finish;
   end

   task automatic clear_line_state();
      pred_char_pos = '0;
      pred_high     = '0;
      pred_type     = '0;
      pred_count    = '0;
      pred_sum      = '0;
      pred_base     = '0;
      pred_byte_pos = '0;
      pred_bad      = 1'b0;
   endtask

   task automatic decode_byte(input logic [7:0] b);
      int      idx;
      int      alen;
      bit      addr_type;
      rsp_type r;
      idx       = pred_byte_pos;
      addr_type = (pred_type >= TYPE_S1 && pred_type <= TYPE_S3);
      alen      = pred_type + 1;
      if (idx == 0) pred_count = b;
      pred_sum = pred_sum + b;
      if (addr_type && idx >= 1 && idx <= alen) begin
         pred_base = {pred_base[23:0], b};
         if (pred_type == TYPE_S2) pred_base = pred_base & ADDR24_MASK;
      end else if (addr_type && idx > alen && idx < pred_count && !pred_bad) begin
         r.record_end   = 1'b0;
         r.byte_address = pred_base + 32'(idx - alen - 1);
         r.data_byte    = b;
         r.status       = STATUS_OK;
         expected_results = {expected_results, r};
      end
      if (pred_byte_pos < BYTE_POS_MAX) pred_byte_pos = pred_byte_pos + 9'd1;
   endtask

   task automatic decode_beat(input logic [7:0] c, input logic last);
      logic [9:0] p;
      logic [3:0] v;
      bit         is_hex;
      rsp_type    r;
      p = pred_char_pos;
      if (last) begin
         r.record_end   = 1'b1;
         r.byte_address = '0;
         r.data_byte    = '0;
         r.status       = STATUS_OK;
         if (pred_bad || p < 10'd4 || p[0]
             || {1'b0, pred_byte_pos} != {2'b00, pred_count} + 10'd1
             || pred_sum != CHECKSUM_GOOD) begin
            r.status = STATUS_BAD;
         end else if (pred_type >= TYPE_S1 && pred_type <= TYPE_S3) begin
            if ({1'b0, pred_byte_pos} < {6'd0, pred_type} + 10'd3) r.status = STATUS_BAD;
         end else begin
            r.status = STATUS_NA;
         end
         expected_results = {expected_results, r};
         clear_line_state();
      end else if (p >= CHAR_POS_MAX) begin
         pred_bad = 1'b1;
      end else begin
         pred_char_pos = p + 10'd1;
         if (p == 10'd0) begin
            if (c != CHAR_S) pred_bad = 1'b1;
         end else if (p == 10'd1) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               pred_type = 4'(c - CHAR_ZERO);
            end else begin
               pred_type = '0;
               pred_bad  = 1'b1;
            end
         end else begin
            is_hex = 1'b1;
            v      = '0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) v = 4'(c - CHAR_ZERO);
            else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) v = 4'(c - CHAR_UPPER_A + 10);
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) v = 4'(c - CHAR_LOWER_A + 10);
            else is_hex = 1'b0;
            if (!is_hex) pred_bad = 1'b1;
            // Even offsets from the first hex digit carry the high nibble.
            if (p[0] == 1'b0) pred_high = v;
            else decode_byte({pred_high, v});
         end
      end
   endtask

   // Drives one beat and returns at the edge that accepts it, or at the end of the idle gap that follows.
   task automatic send_beat(input logic [7:0] c, input logic last);
      int gap;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_beat(c, last);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = tx_idle_enable ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_line();
      foreach (line_buf[k]) send_beat(line_buf[k], 1'b0);
      // The character on a line-end beat is ignored, so it is random.
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return CHAR_ZERO + 8'(n);
      return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n - 4'd10);
   endfunction

   // Builds a record line into line_buf. fill < 0 gives random data bytes.
   task automatic build_record(input int rtype, input logic [31:0] addr, input int ndata,
                               input int fill, input int count_adj, input bit bad_sum);
      logic [7:0] bytes[$];
      logic [7:0] sum;
      int         alen;
      bit         lower;
      alen  = (rtype == 2) ? 3 : (rtype == 3) ? 4 : 2;
      bytes = {};
      bytes = {bytes, 8'(alen + ndata + 1 + count_adj)};
      for (int k = alen - 1; k >= 0; k--) bytes = {bytes, addr[8*k +: 8]};
      for (int k = 0; k < ndata; k++)
         bytes = {bytes, (fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill))};
      sum = '0;
      foreach (bytes[k]) sum = sum + bytes[k];
      sum = ~sum;
      if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
      bytes    = {bytes, sum};
      lower    = 1'($urandom_range(0, 1));
      line_buf = {};
      line_buf = {line_buf, CHAR_S};
      line_buf = {line_buf, CHAR_ZERO + 8'(rtype)};
      foreach (bytes[k]) begin
         line_buf = {line_buf, hex_char(bytes[k][7:4], lower)};
         line_buf = {line_buf, hex_char(bytes[k][3:0], lower)};
      end
   endtask

   task automatic wait_for_results();
      int n;
      n = 0;
      if (req_tvalid) req_tvalid <= 1'b0;
      while (expected_results.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      if (expected_results.size() != 0) begin
         $display("%0t: result beats expected %0d more, actual none", $time,
                  expected_results.size());
         error_count++;
         expected_results = {};
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic test_good_records();
      tx_idle_enable  = 1'b0;
      rx_stall_enable = 1'b0;
      build_record(1, 32'h0000_0000, 0, -1, 0, 0);   send_line();
      build_record(1, 32'h0000_FFFE, 4, 8'hFF, 0, 0); send_line();
      build_record(2, 32'h00FF_FFFE, 3, 8'h00, 0, 0); send_line();
      build_record(3, 32'hFFFF_FFFE, 4, -1, 0, 0);   send_line();
      build_record(3, 32'h1234_5678, 0, -1, 0, 0);   send_line();
      wait_for_results();
   endtask

   task automatic test_other_types();
      tx_idle_enable  = 1'b1;
      rx_stall_enable = 1'b1;
      build_record(0, 32'h0000_0000, 3, -1, 0, 0); send_line();
      build_record(5, 32'h0000_0003, 0, -1, 0, 0); send_line();
      build_record(9, 32'h0000_1000, 0, -1, 0, 0); send_line();
      build_record(7, 32'h0010_0000, 0, -1, 0, 0); send_line();
      wait_for_results();
   endtask

   task automatic test_malformed_lines();
      tx_idle_enable  = 1'b1;
      rx_stall_enable = 1'b1;
      // Empty line, then a line too short to hold a count.
      line_buf = {};
      send_line();
      line_buf = {CHAR_S, CHAR_ZERO + 8'd1};
      send_line();
      // Odd length.
      build_record(1, 32'h0000_1234, 2, -1, 0, 0);
      line_buf = {line_buf, CHAR_ZERO};
      send_line();
      // Non-hex character inside the data.
      build_record(1, 32'h0000_2000, 3, -1, 0, 0);
      line_buf[10] = 8'h47;
      send_line();
      // Type digit that is not a decimal digit, and a wrong leading character.
      build_record(1, 32'h0000_0100, 1, -1, 0, 0);
      line_buf[1] = 8'h58;
      send_line();
      build_record(1, 32'h0000_0100, 1, -1, 0, 0);
      line_buf[0] = 8'h73;
      send_line();
      // Count mismatch in both directions, and a bad checksum.
      build_record(2, 32'h0001_0000, 4, -1, 1, 0);  send_line();
      build_record(2, 32'h0001_0000, 4, -1, -1, 0); send_line();
      build_record(3, 32'h8000_0000, 2, -1, 0, 1);  send_line();
      // Address records whose count is too small for their address width.
      build_record(3, 32'h0000_0000, 0, -1, -1, 0); send_line();
      build_record(1, 32'h0000_0000, 0, -1, -2, 0); send_line();
      wait_for_results();
   endtask

   task automatic test_overlong_line();
      tx_idle_enable  = 1'b1;
      rx_stall_enable = 1'b1;
      // Count FF keeps data bytes flowing up to the count; the line then runs on until it saturates.
      line_buf = {CHAR_S, CHAR_ZERO + 8'd1, hex_char(4'hF, 0), hex_char(4'hF, 0)};
      repeat (1026)
         line_buf = {line_buf, hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)))};
      send_line();
      wait_for_results();
   endtask

   task automatic test_random_lines();
      int         rtype;
      int         ndata;
      int         pos;
      logic [31:0] addr;
      tx_idle_enable  = 1'b1;
      rx_stall_enable = 1'b1;
      while (beats_sent < 1800) begin
         if ($urandom_range(0, 7) == 0) tx_idle_enable = ~tx_idle_enable;
         if ($urandom_range(0, 7) == 0) rx_stall_enable = ~rx_stall_enable;
         if ($urandom_range(0, 99) < 12) begin
            // Noise line, sometimes starting like a record.
            line_buf = {};
            repeat ($urandom_range(0, 40)) line_buf = {line_buf, 8'($urandom_range(0, 255))};
            if (line_buf.size() > 0 && $urandom_range(0, 1)) line_buf[0] = CHAR_S;
         end else begin
            rtype = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 9);
            ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
            addr  = $urandom;
            if ($urandom_range(0, 5) == 0) addr = addr | 32'hFFFF_FFC0;
            build_record(rtype, addr, ndata, -1, 0, 0);
            if ($urandom_range(0, 3) == 0) begin
               pos = $urandom_range(0, line_buf.size() - 1);
               case ($urandom_range(0, 4))
                  0: line_buf[pos] = 8'($urandom_range(0, 255));
                  1: line_buf.delete(pos);
                  2: line_buf.insert(pos, hex_char(4'($urandom_range(0, 15)), 0));
                  3: build_record(rtype, addr, ndata, -1, $urandom_range(1, 3), 0);
                  default: build_record(rtype, addr, ndata, -1, 0, 1);
               endcase
            end
         end
         send_line();
      end
      wait_for_results();
   endtask

   // Receiver stalls come in runs of random length.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_stall_enable && $urandom_range(0, 3) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.record_end   = rsp_tlast;
         got.byte_address = rsp_tdata[31:0];
         got.data_byte    = rsp_tdata[39:32];
         got.status       = rsp_tdata[41:40];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h/%b", $time,
                     rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.record_end != want.record_end) begin
               $display("%0t: record_end expected %b actual %b", $time,
                        want.record_end, got.record_end);
               error_count++;
            end
            if (got.byte_address != want.byte_address) begin
               $display("%0t: byte_address expected %h actual %h", $time,
                        want.byte_address, got.byte_address);
               error_count++;
            end
            if (got.data_byte != want.data_byte) begin
               $display("%0t: data_byte expected %h actual %h", $time,
                        want.data_byte, got.data_byte);
               error_count++;
            end
            if (got.status != want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, got.status);
               error_count++;
            end
            if (rsp_tdata[47:42] != 6'd0) begin
               $display("%0t: tdata pad expected 00 actual %h", $time, rsp_tdata[47:42]);
               error_count++;
            end
         end
      end
   end

   initial begin
      clear_line_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_good_records();
      test_other_types();
      test_malformed_lines();
      test_overlong_line();
      test_random_lines();
      if (error_count == 0) begin
         $display("srecord_line_parser regression: pass");
      end else begin
         $display("srecord_line_parser regression: fail");
      end
      $finish;
   end

endmodule
